// ----- src/gfd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package gfd_pkg;

  localparam int unsigned SATS = 12;
  localparam int unsigned KEEP = 9;

  localparam logic [4:0] KIND_DROP  = 5'd0;
  localparam logic [4:0] KIND_MODE  = 5'd1;
  localparam logic [4:0] KIND_LAT   = 5'd2;
  localparam logic [4:0] KIND_LON   = 5'd3;
  localparam logic [4:0] KIND_ALT   = 5'd4;
  localparam logic [4:0] KIND_DIR   = 5'd5;
  localparam logic [4:0] KIND_CLIMB = 5'd6;
  localparam logic [4:0] KIND_SPEED = 5'd7;
  localparam logic [4:0] KIND_EHPE  = 5'd8;
  localparam logic [4:0] KIND_EVPE  = 5'd9;
  localparam logic [4:0] KIND_GEOID = 5'd10;
  localparam logic [4:0] KIND_PRN   = 5'd11;
  localparam logic [4:0] KIND_SNR   = 5'd12;
  localparam logic [4:0] KIND_YEAR  = 5'd13;
  localparam logic [4:0] KIND_MONTH = 5'd14;
  localparam logic [4:0] KIND_DAY   = 5'd15;
  localparam logic [4:0] KIND_HOUR  = 5'd16;
  localparam logic [4:0] KIND_MIN   = 5'd17;
  localparam logic [4:0] KIND_MASK  = 5'd18;
  localparam logic [4:0] KIND_XHDR  = 5'd19;
  localparam logic [4:0] KIND_XWORD = 5'd20;

  localparam logic [0:0] REG_GAP   = 1'b0;
  localparam logic [0:0] REG_GEOID = 1'b1;

  localparam logic [7:0] MODE_TWO   = 8'd2;
  localparam logic [7:0] MODE_THREE = 8'd3;
  localparam logic [7:0] MODE_FOUR  = 8'd4;

  localparam logic [1:0] TAG_PRN = 2'b01;
  localparam logic [1:0] TAG_SNR = 2'b10;

  localparam logic signed [31:0] LAT_LIM = 32'sd900000000;
  localparam logic signed [31:0] LON_LIM = 32'sd1800000000;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } back_state_t;

  typedef struct packed {
    logic [KEEP-1:0][47:0] frag;
    logic                  full;
    logic                  has8;
  } job_t;

endpackage
`default_nettype wire

// ----- src/gps_fragment_frame_decoder_unit.sv -----
// Channel  | Handshake             | Payload
// input    | in_valid / in_ready   | channel, word_high, word_low, rx_time
// output   | out_valid / out_ready | kind, index, value, last
// config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A fragment that does not close a frame is never held back.
// A closing fragment passes its frame to the result sequencer through a one-entry
// queue; the sequencer emits one result per cycle while out_ready does not hold it.
// A further closing fragment waits until the run ends. Reset is synchronous;
// output back-pressure holds the sequencer and, through it, such a closing fragment.
`timescale 1ns / 1ps
`default_nettype none
module gps_fragment_frame_decoder_unit import gfd_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         channel,
  input  wire logic [31:0]        word_high,
  input  wire logic [15:0]        word_low,
  input  wire logic [31:0]        rx_time,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [4:0]              kind,
  output logic [1:0]              index,
  output logic signed [48:0]      value,
  output logic                    last,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  logic [15:0]        gap_limit_ms;
  logic signed [15:0] default_geoid_cm;
  job_t               job;
  logic               job_valid;
  logic               job_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit_ms     <= 16'd1260;
      default_geoid_cm <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAP:   gap_limit_ms     <= cfg_data;
        REG_GEOID: default_geoid_cm <= cfg_data;
        default:   gap_limit_ms     <= gap_limit_ms;
      endcase
    end
  end

  gfd_front #(
    .SLOTS(SLOTS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .channel      (channel),
    .word_high    (word_high),
    .word_low     (word_low),
    .rx_time      (rx_time),
    .gap_limit_ms (gap_limit_ms),
    .job          (job),
    .job_valid    (job_valid),
    .job_pop      (job_pop)
  );

  gfd_back u_back (
    .clk              (clk),
    .rst              (rst),
    .job              (job),
    .job_valid        (job_valid),
    .job_pop          (job_pop),
    .default_geoid_cm (default_geoid_cm),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .kind             (kind),
    .index            (index),
    .value            (value),
    .last             (last)
  );

endmodule
`default_nettype wire

// ----- src/gfd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gfd_front import gfd_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  channel,
  input  wire logic [31:0] word_high,
  input  wire logic [15:0] word_low,
  input  wire logic [31:0] rx_time,
  input  wire logic [15:0] gap_limit_ms,
  output job_t             job,
  output logic             job_valid,
  input  wire logic        job_pop
);

  logic [SLOTS-1:0] mask;
  logic [15:0]      mask_w;
  logic [3:0]       prev;
  logic [31:0]      last_t;
  logic [47:0]      frag [KEEP];
  logic [31:0]      elapsed;
  logic [35:0]      gap_x10;
  logic             flush;
  logic             in_range;
  logic             accept;
  logic [SLOTS-1:0] mask_set;

  always_comb begin
    mask_w = '0;
    mask_w[SLOTS-1:0] = mask;
    elapsed = rx_time - last_t;
    gap_x10 = {1'b0, elapsed, 3'b000} + {3'b000, elapsed, 1'b0};
    flush = (channel < prev) || mask_w[channel] || (gap_x10 > {20'd0, gap_limit_ms});
    in_range = {1'b0, channel} < 5'(SLOTS);
    mask_set = in_range ? SLOTS'(16'd1 << channel) : '0;
  end

  assign in_ready = !job_valid || !flush;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= '0;
      prev      <= '0;
      last_t    <= '0;
      job_valid <= 1'b0;
    end else begin
      if (job_pop) begin
        job_valid <= 1'b0;
      end
      if (accept) begin
        if (flush) begin
          job_valid <= 1'b1;
        end
        mask   <= (flush ? '0 : mask) | mask_set;
        prev   <= channel;
        last_t <= rx_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ({1'b0, channel} < 5'(KEEP))) begin
      frag[channel] <= {word_high, word_low};
    end
    if (accept && flush) begin
      for (int k = 0; k < KEEP; k++) begin
        job.frag[k] <= mask_w[k] ? frag[k] : 48'd0;
      end
      job.full <= &mask_w[7:0];
      job.has8 <= mask_w[8];
    end
  end

endmodule
`default_nettype wire

// ----- src/gfd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gfd_back import gfd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire job_t               job,
  input  wire logic               job_valid,
  output logic                    job_pop,
  input  wire logic signed [15:0] default_geoid_cm,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [4:0]              kind,
  output logic [1:0]              index,
  output logic signed [48:0]      value,
  output logic                    last
);

  back_state_t       state, state_next;
  logic [4:0]        kind_r, kind_next;
  logic [1:0]        idx_r, idx_next;
  logic              is_last;
  logic              emit;
  logic              load;
  logic [5:0]        prn [SATS];
  logic [5:0]        snr [SATS];
  logic [7:0]        mode_raw;
  logic [7:0]        mode;
  logic              m2;
  logic              m4;
  logic signed [16:0] geoid;
  logic signed [31:0] lat_raw, lon_raw, alt_raw;
  logic signed [31:0] lat_c, lon_c;
  logic signed [32:0] alt;
  logic [15:0]       dir_raw, climb_raw, speed_raw;
  logic [31:0]       date;
  logic [35:0]       grp;
  logic [47:0]       xw;
  logic [48:0]       val_next;

  function automatic logic [31:0] hi(input job_t j, input int k);
    return j.frag[k][47:16];
  endfunction

  function automatic logic [15:0] lo(input job_t j, input int k);
    return j.frag[k][15:0];
  endfunction

  always_comb begin
    mode_raw = job.frag[0][31:24];
    mode = (mode_raw == MODE_THREE || mode_raw == MODE_FOUR) ? mode_raw : MODE_TWO;
    m2 = (mode == MODE_TWO);
    m4 = (mode == MODE_FOUR);
    if (m2) begin
      geoid = 17'(signed'(job.frag[5][47:32]))
              + ((job.frag[5][47] && (job.frag[5][31:16] != 16'd0)) ? 17'sd1 : 17'sd0);
    end else begin
      geoid = 17'(default_geoid_cm);
    end
    lat_raw   = m2 ? hi(job, 2) : hi(job, 1);
    lon_raw   = m2 ? hi(job, 3) : hi(job, 2);
    alt_raw   = m2 ? hi(job, 4) : hi(job, 3);
    dir_raw   = m2 ? lo(job, 3) : lo(job, 1);
    climb_raw = m2 ? lo(job, 4) : lo(job, 2);
    speed_raw = m2 ? lo(job, 2) : lo(job, 0);
    lat_c = (lat_raw > LAT_LIM) ? LAT_LIM : ((lat_raw < -LAT_LIM) ? -LAT_LIM : lat_raw);
    lon_c = (lon_raw > LON_LIM) ? LON_LIM : ((lon_raw < -LON_LIM) ? -LON_LIM : lon_raw);
    alt = 33'(alt_raw) + 33'(geoid);
    date = hi(job, 8);
    grp = '0;
    for (int k = 0; k < 6; k++) begin
      grp[6*k +: 6] = (kind_r == KIND_PRN) ? prn[6*idx_r[0] + k] : snr[6*idx_r[0] + k];
    end
    xw = job.frag[4 + idx_r];
  end

  always_comb begin
    val_next = '0;
    unique case (kind_r)
      KIND_DROP:  val_next = '0;
      KIND_MODE:  val_next = {41'd0, mode};
      KIND_LAT:   val_next = 49'(lat_c);
      KIND_LON:   val_next = 49'(lon_c);
      KIND_ALT:   val_next = 49'(alt);
      KIND_DIR:   val_next = 49'(signed'(dir_raw));
      KIND_CLIMB: val_next = 49'(signed'(climb_raw));
      KIND_SPEED: val_next = 49'(signed'(speed_raw));
      KIND_EHPE:  val_next = {33'd0, job.frag[5][31:16]};
      KIND_EVPE:  val_next = 49'(signed'(lo(job, 5)));
      KIND_GEOID: val_next = 49'(geoid);
      KIND_PRN, KIND_SNR: val_next = {13'd0, grp};
      KIND_YEAR:  val_next = {37'd0, date[31:20]};
      KIND_MONTH: val_next = {45'd0, date[19:16]};
      KIND_DAY:   val_next = {44'd0, date[15:11]};
      KIND_HOUR:  val_next = {44'd0, date[10:6]};
      KIND_MIN:   val_next = {43'd0, date[5:0]};
      KIND_MASK:  val_next = {41'd0, job.frag[8][15:8]};
      KIND_XHDR:  val_next = {33'd0, lo(job, 3)};
      KIND_XWORD: val_next = {1'b0, xw};
      default:    val_next = '0;
    endcase
  end

  always_comb begin
    kind_next = kind_r;
    idx_next  = 2'd0;
    is_last   = 1'b0;
    case (kind_r) inside
      KIND_DROP: is_last = 1'b1;
      [KIND_MODE:KIND_CLIMB], KIND_EHPE, [KIND_YEAR:KIND_HOUR]: kind_next = kind_r + 5'd1;
      KIND_SPEED: kind_next = m2 ? KIND_EHPE : KIND_GEOID;
      KIND_EVPE:  kind_next = KIND_GEOID;
      KIND_GEOID: kind_next = KIND_PRN;
      KIND_PRN: begin
        kind_next = (idx_r == 2'd0) ? KIND_PRN : KIND_SNR;
        idx_next  = (idx_r == 2'd0) ? 2'd1 : 2'd0;
      end
      KIND_SNR: begin
        kind_next = (idx_r == 2'd0) ? KIND_SNR : KIND_YEAR;
        idx_next  = (idx_r == 2'd0) ? 2'd1 : 2'd0;
      end
      KIND_MIN: begin
        if (job.has8) begin
          kind_next = KIND_MASK;
        end else if (m4) begin
          kind_next = KIND_XHDR;
        end else begin
          is_last = 1'b1;
        end
      end
      KIND_MASK: begin
        kind_next = KIND_XHDR;
        is_last   = !m4;
      end
      KIND_XHDR: begin
        kind_next = KIND_XWORD;
        is_last   = (lo(job, 3) == 16'd0);
      end
      KIND_XWORD: begin
        idx_next = idx_r + 2'd1;
        is_last  = (idx_r == 2'd3);
      end
      default: is_last = 1'b1;
    endcase
  end

  always_comb begin
    state_next = state;
    load       = 1'b0;
    emit       = 1'b0;
    job_pop    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (job_valid) begin
          load       = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!out_valid || out_ready) begin
          emit = 1'b1;
          if (is_last) begin
            job_pop    = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      for (int s = 0; s < SATS; s++) begin
        prn[s] <= '0;
        snr[s] <= '0;
      end
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load && job.full) begin
        if (m2) begin
          for (int g = 0; g < 2; g++) begin
            if (job.frag[6 + g][47:46] == TAG_PRN) begin
              prn[6*g+0] <= job.frag[6 + g][45:40];
              prn[6*g+1] <= job.frag[6 + g][37:32];
              prn[6*g+2] <= job.frag[6 + g][29:24];
              prn[6*g+3] <= job.frag[6 + g][21:16];
              prn[6*g+4] <= job.frag[6 + g][13:8];
              prn[6*g+5] <= job.frag[6 + g][5:0];
            end
            if (job.frag[6 + g][47:46] == TAG_SNR) begin
              snr[6*g+0] <= job.frag[6 + g][45:40];
              snr[6*g+1] <= job.frag[6 + g][37:32];
              snr[6*g+2] <= job.frag[6 + g][29:24];
              snr[6*g+3] <= job.frag[6 + g][21:16];
              snr[6*g+4] <= job.frag[6 + g][13:8];
              snr[6*g+5] <= job.frag[6 + g][5:0];
            end
          end
        end else begin
          for (int s = 0; s < SATS; s++) begin
            prn[s] <= '0;
            snr[s] <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= job.full ? KIND_MODE : KIND_DROP;
      idx_r  <= 2'd0;
    end else if (emit) begin
      kind_r <= kind_next;
      idx_r  <= idx_next;
    end
    if (emit) begin
      kind  <= kind_r;
      index <= idx_r;
      value <= val_next;
      last  <= is_last;
    end
  end

endmodule
`default_nettype wire

// ----- bench/tb_gps_fragment_frame_decoder_unit.sv -----
`timescale 1ns / 1ps
module tb_gps_fragment_frame_decoder_unit;
  import gfd_pkg::*;

  typedef struct packed {
    logic [4:0]  kind;
    logic [1:0]  index;
    logic [48:0] value;
    logic        last;
  } result_t;

  class frame_scoreboard;
    logic [47:0]        frag [16];
    logic [15:0]        rcvd;
    logic [3:0]         prev_ch;
    logic [31:0]        last_t;
    logic [5:0]         prn [SATS];
    logic [5:0]         snr [SATS];
    logic [15:0]        gap_ms;
    logic signed [15:0] geoid_cm;
    result_t            pending [$];

    function new();
      for (int k = 0; k < 16; k++) frag[k] = '0;
      for (int k = 0; k < SATS; k++) begin
        prn[k] = '0;
        snr[k] = '0;
      end
      rcvd = '0;
      prev_ch = '0;
      last_t = '0;
      gap_ms = 16'd1260;
      geoid_cm = '0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [15:0] data);
      if (idx == REG_GAP) gap_ms = data;
      else geoid_cm = data;
    endfunction

    function logic [31:0] hi(int k);
      return frag[k][47:16];
    endfunction

    function logic [15:0] lo(int k);
      return frag[k][15:0];
    endfunction

    function void put(logic [4:0] kind, int idx, longint v);
      result_t r;
      r.kind = kind;
      r.index = idx[1:0];
      r.value = v[48:0];
      r.last = 1'b0;
      pending.push_back(r);
    endfunction

    function longint lim(longint v, longint l);
      if (v > l) return l;
      if (v < -l) return -l;
      return v;
    endfunction

    function longint group(bit use_snr, int g);
      longint v;
      v = 0;
      for (int k = 0; k < 6; k++)
        v |= longint'(use_snr ? snr[6*g+k] : prn[6*g+k]) << (6 * k);
      return v;
    endfunction

    function void decode();
      logic [7:0]  md;
      logic [31:0] h, l, d;
      bit          m2;
      longint      geo;
      md = frag[0][31:24];
      if (md < MODE_TWO || md > MODE_FOUR) md = MODE_TWO;
      m2 = (md == MODE_TWO);
      if (m2) begin
        geo = longint'($signed(hi(5))) / 65536;
        for (int g = 0; g < 2; g++) begin
          h = hi(6 + g);
          l = {16'd0, lo(6 + g)};
          for (int k = 0; k < 6; k++) begin
            logic [5:0] s;
            case (k)
              0: s = h[29:24];
              1: s = h[21:16];
              2: s = h[13:8];
              3: s = h[5:0];
              4: s = l[13:8];
              default: s = l[5:0];
            endcase
            if (h[31:30] == TAG_PRN) prn[6*g+k] = s;
            if (h[31:30] == TAG_SNR) snr[6*g+k] = s;
          end
        end
      end else begin
        geo = longint'(geoid_cm);
        for (int k = 0; k < SATS; k++) begin
          prn[k] = '0;
          snr[k] = '0;
        end
      end
      put(KIND_MODE, 0, longint'(md));
      put(KIND_LAT, 0, lim(longint'($signed(hi(m2 ? 2 : 1))), longint'(LAT_LIM)));
      put(KIND_LON, 0, lim(longint'($signed(hi(m2 ? 3 : 2))), longint'(LON_LIM)));
      put(KIND_ALT, 0, longint'($signed(hi(m2 ? 4 : 3))) + geo);
      put(KIND_DIR, 0, longint'($signed(lo(m2 ? 3 : 1))));
      put(KIND_CLIMB, 0, longint'($signed(lo(m2 ? 4 : 2))));
      put(KIND_SPEED, 0, longint'($signed(lo(m2 ? 2 : 0))));
      if (m2) begin
        put(KIND_EHPE, 0, longint'(frag[5][31:16]));
        put(KIND_EVPE, 0, longint'($signed(lo(5))));
      end
      put(KIND_GEOID, 0, geo);
      for (int g = 0; g < 2; g++) put(KIND_PRN, g, group(1'b0, g));
      for (int g = 0; g < 2; g++) put(KIND_SNR, g, group(1'b1, g));
      d = hi(8);
      put(KIND_YEAR, 0, longint'(d[31:20]));
      put(KIND_MONTH, 0, longint'(d[19:16]));
      put(KIND_DAY, 0, longint'(d[15:11]));
      put(KIND_HOUR, 0, longint'(d[10:6]));
      put(KIND_MIN, 0, longint'(d[5:0]));
      if (rcvd[8]) put(KIND_MASK, 0, longint'(frag[8][15:8]));
      if (md == MODE_FOUR) begin
        put(KIND_XHDR, 0, longint'(lo(3)));
        if (lo(3) != 0)
          for (int k = 0; k < 4; k++) put(KIND_XWORD, k, longint'(frag[4+k]));
      end
    endfunction

    function void note_input(logic [3:0] ch, logic [31:0] wh, logic [15:0] wl,
                             logic [31:0] t);
      logic [31:0] elapsed;
      bit          flush;
      result_t     r;
      elapsed = t - last_t;
      flush = (ch < prev_ch) || rcvd[ch] || (longint'(elapsed) * 10 > longint'(gap_ms));
      if (flush) begin
        if (rcvd[7:0] == 8'hFF) decode();
        else put(KIND_DROP, 0, 0);
        r = pending.pop_back();
        r.last = 1'b1;
        pending.push_back(r);
        for (int k = 0; k < 16; k++) frag[k] = '0;
        rcvd = '0;
      end
      frag[ch] = {wh, wl};
      rcvd[ch] = 1'b1;
      prev_ch = ch;
      last_t = t;
    endfunction

    function string check(result_t got);
      result_t want;
      if (pending.size() == 0)
        return $sformatf("unexpected result kind %0d value %0h", got.kind, got.value);
      want = pending.pop_front();
      if (got !== want)
        return $sformatf("kind %0d/%0d index %0d/%0d value %0h/%0h last %0b/%0b (got/exp)",
                         got.kind, want.kind, got.index, want.index,
                         got.value, want.value, got.last, want.last);
      return "";
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [3:0]         channel = '0;
  logic [31:0]        word_high = '0;
  logic [15:0]        word_low = '0;
  logic [31:0]        rx_time = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [4:0]         kind;
  logic [1:0]         index;
  logic signed [48:0] value;
  logic               last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [0:0]         cfg_index = REG_GAP;
  logic [15:0]        cfg_data = '0;

  frame_scoreboard sb = new();
  int          errors = 0;
  int          items = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_start = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_cnt = 0;
  logic [31:0] cur_t;

  gps_fragment_frame_decoder_unit uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("gps_fragment_frame_decoder_unit regression: fail");
    $finish;
  end

  task automatic report(string msg);
    errors++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    if (hold_start && !hold_done) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt >= 400) hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    string msg;
    if (!rst && out_valid && out_ready) begin
      msg = sb.check('{kind, index, value, last});
      if (msg != "") report(msg);
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_fragment(logic [3:0] ch, logic [31:0] wh, logic [15:0] wl,
                               logic [31:0] t);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    channel <= ch;
    word_high <= wh;
    word_low <= wl;
    rx_time <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(ch, wh, wl, t);
    items++;
  endtask

  // advance time, staying inside the gap limit unless a gap is wanted
  function automatic logic [31:0] next_time(bit long_gap);
    int unsigned span;
    span = sb.gap_ms / 10;
    if (long_gap) cur_t += span + 1 + $urandom_range(1000);
    else cur_t += $urandom_range(span > 50 ? 50 : span);
    return cur_t;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_frame();
    int          top, kind_sel;
    logic [31:0] wh;
    logic [15:0] wl;
    bit          gap;
    kind_sel = $urandom_range(9);
    top = (kind_sel < 7) ? 8 + $urandom_range(1) : $urandom_range(15);
    for (int c = 0; c <= top; c++) begin
      if (kind_sel == 9 && $urandom_range(3) == 0) continue;
      wh = $urandom();
      wl = 16'($urandom());
      if (c == 0)
        case ($urandom_range(4))
          0: wh[15:8] = MODE_TWO;
          1: wh[15:8] = MODE_THREE;
          2, 3: wh[15:8] = MODE_FOUR;
          default: ;
        endcase
      if (c == 3 && $urandom_range(3) == 0) wl = '0;
      gap = (kind_sel == 8 && c == top);
      send_fragment(4'(c), wh, wl, next_time(gap));
      if (kind_sel == 7 && c == 4)
        send_fragment(4'(c), $urandom(), 16'($urandom()), next_time(0));
    end
  endtask

  task automatic run_phase(int sidle, int rstall, int quota);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    while (items < quota) random_frame();
    send_fragment(4'd0, $urandom(), 16'($urandom()), next_time(1));
    drain();
  endtask

  initial begin
    cur_t = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int c = 0; c <= 8; c++) send_fragment(4'(c), '0, '0, next_time(0));
    for (int c = 0; c <= 7; c++) send_fragment(4'(c), '1, '1, next_time(0));
    send_fragment(4'd7, '1, '1, next_time(1));
    send_fragment(4'd3, 32'h8000_0000, 16'h8000, next_time(0));
    send_fragment(4'd5, 32'h7FFF_FFFF, 16'h7FFF, next_time(1));
    send_fragment(4'd2, $urandom(), 16'($urandom()), next_time(0));
    cur_t = 32'hFFFF_FFF8;
    send_fragment(4'd9, $urandom(), 16'($urandom()), cur_t);
    send_fragment(4'd15, $urandom(), 16'($urandom()), next_time(0));
    drain();
    write_reg(REG_GAP, 16'd0);
    write_reg(REG_GEOID, 16'h8000);
    run_phase(19, 80, 60);
    write_reg(REG_GAP, 16'hFFFF);
    write_reg(REG_GEOID, 16'h7FFF);
    run_phase(80, 19, 180);
    write_reg(REG_GAP, 16'd1260);
    write_reg(REG_GEOID, 16'($urandom()));
    hold_start <= 1'b1;
    run_phase(0, 0, 325);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && sb.pending.size() == 0)
      $display("gps_fragment_frame_decoder_unit regression: pass");
    else
      $display("gps_fragment_frame_decoder_unit regression: fail");
    $finish;
  end

endmodule
